// ===== hw/rtl/lef_pkg.sv =====
// ----------------------------------------------------------------------------
// lef_pkg: shared types and constants of the Laplacian edge filter
// Frame limits, field widths, register indexes and the word types that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package lef_pkg;

   // Frame limits; the row stores are MAX_WIDTH entries deep.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Field widths fixed by the interface.
   localparam int PIX_W     = 8;
   localparam int DIM_W     = 12;
   localparam int POS_OUT_W = 11;
   localparam int CSR_IDX_W = 1;

   // Widths that follow from the frame limits.
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);

   // Window geometry: three rows of three taps, tap 2 of a row is the newest.
   localparam int WIN_DIM  = 3;
   localparam int WIN_SIZE = WIN_DIM * WIN_DIM;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [DIM_W-1:0]     WIDTH_RESET      = DIM_W'(640);
   localparam logic [DIM_W-1:0]     HEIGHT_RESET     = DIM_W'(480);

   typedef logic [PIX_W-1:0] pix_type;

   // Position information that follows an item down the pipeline.
   typedef struct packed {
      logic                 emit;
      logic                 frame_end;
      logic [POS_OUT_W-1:0] out_col;
      logic [POS_OUT_W-1:0] out_row;
   } meta_type;

   // One result word.
   typedef struct packed {
      logic                 frame_end;
      logic [POS_OUT_W-1:0] out_row;
      logic [POS_OUT_W-1:0] out_col;
      pix_type              pixel_out;
   } rsp_word_type;

   // Effective frame dimension: a written value is held to 3..hi_lim.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned hi_lim);
      logic [DIM_W-1:0] res;
      res = v;
      if (v < DIM_W'(3)) begin
         res = DIM_W'(3);
      end else if (32'(v) > 32'(hi_lim)) begin
         res = DIM_W'(hi_lim);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/lef_cell.sv =====
// ----------------------------------------------------------------------------
// lef_cell: one tap of the 3x3 pixel window
// Holds one pixel and takes its neighbor's pixel whenever the window shifts.
// ----------------------------------------------------------------------------
module lef_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift_en,
   input  lef_pkg::pix_type pix_d,
   output lef_pkg::pix_type pix_q
);

   lef_pkg::pix_type pix_ff;

   // The tap clears on reset and loads on every window shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (shift_en) begin
         pix_ff <= pix_d;
      end
   end

   assign pix_q = pix_ff;

endmodule

// ===== hw/rtl/lef_line_buf.sv =====
// ----------------------------------------------------------------------------
// lef_line_buf: the two row stores
// The older store holds the row above the newer one. A read fetches both
// rows at a column; the later write moves the newer pixel to the older
// store and puts the incoming pixel into the newer store at that column.
// ----------------------------------------------------------------------------
module lef_line_buf (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [lef_pkg::ADDR_W-1:0] rd_addr,
   input  logic                       wr_en,
   input  logic [lef_pkg::ADDR_W-1:0] wr_addr,
   input  lef_pkg::pix_type           wr_pix,
   output lef_pkg::pix_type           top_pix,
   output lef_pkg::pix_type           mid_pix
);

   lef_pkg::pix_type older_mem [lef_pkg::MAX_WIDTH];
   lef_pkg::pix_type newer_mem [lef_pkg::MAX_WIDTH];
   lef_pkg::pix_type top_ff;
   lef_pkg::pix_type mid_ff;

   // Registered read of both rows; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= older_mem[rd_addr];
         mid_ff <= newer_mem[rd_addr];
      end
   end

   // Write back: the middle row ages into the older store.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= mid_ff;
         newer_mem[wr_addr] <= wr_pix;
      end
   end

   assign top_pix = top_ff;
   assign mid_pix = mid_ff;

endmodule

// ===== hw/rtl/lef_kernel.sv =====
// ----------------------------------------------------------------------------
// lef_kernel: Laplacian sum over the 3x3 window
// Doubled sum of corners, twice the edges and minus twelve times the
// center, halved with truncation and saturated to the pixel range.
// ----------------------------------------------------------------------------
module lef_kernel (
   input  lef_pkg::pix_type win [lef_pkg::WIN_SIZE],
   output lef_pkg::pix_type pixel_out
);

   logic [9:0]         corners;
   logic [9:0]         edges;
   logic [11:0]        center_x12;
   logic signed [13:0] dsum;
   logic [12:0]        half;

   // Tap sums; taps are row-major with the center at index 4.
   assign corners = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
   assign edges   = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
   assign center_x12 = {1'b0, win[4], 3'b000} + {2'b00, win[4], 2'b00};
   assign dsum = $signed({4'b0000, corners}) + $signed({3'b000, edges, 1'b0})
               - $signed({2'b00, center_x12});
   assign half = dsum[13:1];

   // Negative sums give zero, large ones clip at full scale.
   always_comb begin
      if (dsum[13]) begin
         pixel_out = '0;
      end else if (half > 13'd255) begin
         pixel_out = '1;
      end else begin
         pixel_out = half[7:0];
      end
   end

endmodule

// ===== hw/rtl/laplacian_edge_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3: streaming 3x3 Laplacian edge detector
// Raster-order grayscale pixels in, one edge value out for every interior
// pixel of the frame. Two row stores feed a 3x3 window of nine cells.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Word                                 | Width
//  --------+-----------+--------------------------------------+------
//  req_    | in        | tdata: pixel_in                      | 8
//  rsp_    | out       | tdata: pixel_out, out_col, out_row;  | 32
//          |           | tlast: frame_end                     |
//  csr_    | in        | index 0 image_width, 1 image_height  | 12
//
// One pixel word is taken every cycle while the skid register is empty. A result
// word follows its pixel through the row store read, the window shift and the
// kernel into the output register. Reset clears the positions, the window and
// the registers to 640 x 480; the row stores are not cleared. A stalled result
// goes to a skid register, so one more word is accepted; the pipeline holds
// while that register is full.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_3x3 (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel words: [7:0] pixel_in.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   // Result words: [7:0] pixel_out, [18:8] out_col, [29:19] out_row, zero above.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   // Register writes.
   input  logic                          csr_we,
   input  logic [lef_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lef_pkg::DIM_W-1:0]     csr_wdata
);

   logic [lef_pkg::DIM_W-1:0]  width_ff;
   logic [lef_pkg::DIM_W-1:0]  height_ff;
   logic [lef_pkg::DIM_W-1:0]  width_eff;
   logic [lef_pkg::DIM_W-1:0]  height_eff;
   logic [lef_pkg::ADDR_W-1:0] col_ff;
   logic [lef_pkg::ADDR_W-1:0] col_in;
   logic [lef_pkg::ROW_W-1:0]  row_ff;
   logic [lef_pkg::ROW_W-1:0]  row_in;
   logic                       last_col;
   logic                       last_row;
   logic                       advance;
   logic                       accept;
   lef_pkg::meta_type          meta0;

   logic                       s1_valid_ff;
   lef_pkg::pix_type           s1_pix_ff;
   logic [lef_pkg::ADDR_W-1:0] s1_addr_ff;
   lef_pkg::meta_type          s1_meta_ff;
   logic                       s2_valid_ff;
   lef_pkg::meta_type          s2_meta_ff;
   logic                       shift_en;

   lef_pkg::pix_type           top_pix;
   lef_pkg::pix_type           mid_pix;
   lef_pkg::pix_type           feed [lef_pkg::WIN_DIM];
   lef_pkg::pix_type           win [lef_pkg::WIN_SIZE];
   lef_pkg::pix_type           kern_pix;

   logic                       push;
   lef_pkg::rsp_word_type      new_word;
   logic                       rsp_valid_ff;
   lef_pkg::rsp_word_type      rsp_word_ff;
   logic                       skid_valid_ff;
   lef_pkg::rsp_word_type      skid_word_ff;
   logic                       pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lef_pkg::WIDTH_RESET;
         height_ff <= lef_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lef_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            lef_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_eff  = lef_pkg::clamp_dim(width_ff, lef_pkg::MAX_WIDTH);
   assign height_eff = lef_pkg::clamp_dim(height_ff, lef_pkg::MAX_HEIGHT);

   // The whole pipeline moves unless the skid register is occupied.
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // Raster position of the incoming pixel.
   assign last_col = (32'(col_ff) + 32'd1) >= 32'(width_eff);
   assign last_row = (32'(row_ff) + 32'd1) >= 32'(height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Interior positions produce a result for the pixel up and to the left.
   always_comb begin
      meta0.emit      = (col_ff >= lef_pkg::ADDR_W'(2)) && (row_ff >= lef_pkg::ROW_W'(2));
      meta0.frame_end = last_col && last_row;
      meta0.out_col   = lef_pkg::POS_OUT_W'(lef_pkg::ADDR_W'(col_ff - 1'b1));
      meta0.out_row   = lef_pkg::POS_OUT_W'(lef_pkg::ROW_W'(row_ff - 1'b1));
   end

   // Stage 1: row stores are read while the pixel waits beside them.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_addr_ff <= col_ff;
         s1_meta_ff <= meta0;
      end
      if (shift_en) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   assign shift_en = advance && s1_valid_ff;

   lef_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (shift_en),
      .wr_addr (s1_addr_ff),
      .wr_pix  (s1_pix_ff),
      .top_pix (top_pix),
      .mid_pix (mid_pix)
   );

   // Stage 2: a row of cells per window row, each handing its pixel left.
   assign feed[0] = top_pix;
   assign feed[1] = mid_pix;
   assign feed[2] = s1_pix_ff;

   for (genvar gr = 0; gr < lef_pkg::WIN_DIM; gr++) begin : g_row
      for (genvar gc = 0; gc < lef_pkg::WIN_DIM; gc++) begin : g_tap
         lef_pkg::pix_type tap_d;
         if (gc == lef_pkg::WIN_DIM - 1) begin : g_newest
            assign tap_d = feed[gr];
         end else begin : g_older
            assign tap_d = win[gr * lef_pkg::WIN_DIM + gc + 1];
         end
         lef_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .pix_d    (tap_d),
            .pix_q    (win[gr * lef_pkg::WIN_DIM + gc])
         );
      end
   end

   // Stage 3: kernel into the output register.
   lef_kernel u_kernel (
      .win       (win),
      .pixel_out (kern_pix)
   );

   assign push = advance && s2_valid_ff && s2_meta_ff.emit;
   assign pop  = rsp_valid_ff && rsp_tready;

   always_comb begin
      new_word.frame_end = s2_meta_ff.frame_end;
      new_word.out_row   = s2_meta_ff.out_row;
      new_word.out_col   = s2_meta_ff.out_col;
      new_word.pixel_out = kern_pix;
   end

   // Output register with one skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_word_ff <= skid_word_ff;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_word_ff <= new_word;
         end else begin
            skid_word_ff <= new_word;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_word_ff.frame_end;
   assign rsp_tdata  = {2'b00, rsp_word_ff.out_row, rsp_word_ff.out_col,
                        rsp_word_ff.pixel_out};

endmodule
